@@ rtl/assert_macros.svh @@
// Assertion helpers for the RTL. Each check is clocked on clk and is
// switched off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge.
`define MPCS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent that must hold in the cycle after the antecedent.
`define MPCS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/mpcs_pkg.sv @@
package mpcs_pkg;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 31;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Z       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_FIELD_LIMIT    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_CALIB_FLOOR    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_GAIN_NUMERATOR = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_GAIN   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_AXIS_LAYOUT    = 3'd7;

	// Register reset values.
	localparam logic [14:0] FIELD_LIMIT_RST    = 15'd1000;
	localparam logic [14:0] CALIB_FLOOR_RST    = 15'd100;
	localparam logic [30:0] GAIN_NUMERATOR_RST = 31'd11468800;
	localparam logic [15:0] DEFAULT_GAIN_RST   = 16'd16384;
	localparam logic [8:0]  AXIS_LAYOUT_RST    = 9'd36;
	localparam logic [15:0] GAIN_RST           = 16'd16384;
	localparam logic [15:0] GAIN_SAT           = 16'hFFFF;

	// Request codes.
	localparam logic [1:0] REQ_TICK  = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_NACK  = 2'd2;
	localparam logic [1:0] REQ_FAULT = 2'd3;

	// Action codes.
	localparam logic [3:0] ACT_NONE        = 4'd0;
	localparam logic [3:0] ACT_WR_RESET    = 4'd1;
	localparam logic [3:0] ACT_WR_SELFTEST = 4'd2;
	localparam logic [3:0] ACT_WR_CONT     = 4'd3;
	localparam logic [3:0] ACT_START_READ  = 4'd4;
	localparam logic [3:0] ACT_FIELD       = 4'd5;
	localparam logic [3:0] ACT_GAINS       = 4'd6;
	localparam logic [3:0] ACT_RESTART     = 4'd7;
	localparam logic [3:0] ACT_BUS_REINIT  = 4'd8;

	// Bring-up steps.
	localparam logic [2:0] STEP_START    = 3'd0;
	localparam logic [2:0] STEP_RESET    = 3'd2;
	localparam logic [2:0] STEP_SELFTEST = 3'd4;
	localparam logic [2:0] STEP_CAL      = 3'd5;
	localparam logic [2:0] STEP_CONT     = 3'd6;
	localparam logic [2:0] STEP_DATA     = 3'd7;
	localparam logic [1:0] PAUSE_TICKS   = 2'd2;

	// Axis numbering; an axis selector of AXIS_NONE reads as zero.
	localparam logic [1:0] AXIS_FIRST = 2'd0;
	localparam logic [1:0] AXIS_LAST  = 2'd2;
	localparam logic [1:0] AXIS_NONE  = 2'd3;

	// Quotient bits produced by the serial divider.
	localparam int          DIV_BITS    = 16;
	localparam logic [3:0]  DIV_CNT_TOP = 4'(DIV_BITS - 1);

	typedef struct packed {
		logic [1:0]          req_type;
		logic signed [15:0]  raw_first;
		logic signed [15:0]  raw_second;
		logic signed [15:0]  raw_third;
	} mpcs_in_t;

	typedef struct packed {
		logic [3:0]          action;
		logic signed [15:0]  field_x;
		logic signed [15:0]  field_y;
		logic signed [15:0]  field_z;
		logic [15:0]         gain_word_first;
		logic [15:0]         gain_word_second;
		logic [15:0]         gain_word_third;
	} mpcs_out_t;

	// Controller to datapath.
	typedef struct packed {
		logic        load;
		logic        div_start;
		logic        mul;
		logic        fld;
		logic        clr_fld;
		logic        push;
		logic [1:0]  axis;
		logic [3:0]  act;
	} mpcs_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic div_done;
		logic ok;
	} mpcs_sts_t;

endpackage

@@ rtl/mpcs_dp.sv @@
module mpcs_dp
	import mpcs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  mpcs_in_t               in_data,
	input  logic                   cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  mpcs_cmd_t              cmd,
	output mpcs_sts_t              sts,
	output mpcs_out_t              out_data
);

	// Configuration registers.
	logic [15:0] off_q [3];
	logic [14:0] lim_q;
	logic [14:0] floor_q;
	logic [30:0] num_q;
	logic [15:0] dflt_q;
	logic [8:0]  lay_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q[0] <= '0;
			off_q[1] <= '0;
			off_q[2] <= '0;
			lim_q    <= FIELD_LIMIT_RST;
			floor_q  <= CALIB_FLOOR_RST;
			num_q    <= GAIN_NUMERATOR_RST;
			dflt_q   <= DEFAULT_GAIN_RST;
			lay_q    <= AXIS_LAYOUT_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_OFFSET_X:       off_q[0] <= cfg_data[15:0];
				CFG_OFFSET_Y:       off_q[1] <= cfg_data[15:0];
				CFG_OFFSET_Z:       off_q[2] <= cfg_data[15:0];
				CFG_FIELD_LIMIT:    lim_q    <= cfg_data[14:0];
				CFG_CALIB_FLOOR:    floor_q  <= cfg_data[14:0];
				CFG_GAIN_NUMERATOR: num_q    <= cfg_data[30:0];
				CFG_DEFAULT_GAIN:   dflt_q   <= cfg_data[15:0];
				CFG_AXIS_LAYOUT:    lay_q    <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	// Latched sensor words.
	logic signed [15:0] raw_q [3];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			raw_q[0] <= in_data.raw_first;
			raw_q[1] <= in_data.raw_second;
			raw_q[2] <= in_data.raw_third;
		end
	end

	logic [15:0] gains_q [3];

	// Per-axis layout fields.
	logic [1:0] sel_w;
	logic       neg_w;
	logic [15:0] off_rd;

	always_comb begin
		case (cmd.axis)
			2'd0: begin
				sel_w  = lay_q[1:0];
				neg_w  = lay_q[6];
				off_rd = off_q[0];
			end
			2'd1: begin
				sel_w  = lay_q[3:2];
				neg_w  = lay_q[7];
				off_rd = off_q[1];
			end
			default: begin
				sel_w  = lay_q[5:4];
				neg_w  = lay_q[8];
				off_rd = off_q[2];
			end
		endcase
	end

	// One shared read port into the sensor words and gains.
	logic [1:0]         rd_idx;
	logic signed [15:0] raw_rd;
	logic [15:0]        gain_rd;

	assign rd_idx = cmd.mul ? sel_w : cmd.axis;

	always_comb begin
		case (rd_idx)
			2'd0: begin
				raw_rd  = raw_q[0];
				gain_rd = gains_q[0];
			end
			2'd1: begin
				raw_rd  = raw_q[1];
				gain_rd = gains_q[1];
			end
			2'd2: begin
				raw_rd  = raw_q[2];
				gain_rd = gains_q[2];
			end
			default: begin
				raw_rd  = '0;
				gain_rd = gains_q[0];
			end
		endcase
	end

	// Calibration word checks.
	logic d_good;
	logic d_sat;

	assign d_good = ($signed({raw_rd[15], raw_rd}) > $signed({2'b00, floor_q}))
		&& ($signed({raw_rd[15], raw_rd}) < $signed({2'b00, lim_q}));
	assign d_sat  = num_q >= {raw_rd[14:0], 16'h0000};

	// Restoring divider, one quotient bit per cycle.
	logic        div_busy_q;
	logic        div_done_q;
	logic [3:0]  div_cnt_q;
	logic [14:0] div_d_q;
	logic [14:0] div_rem_q;
	logic [15:0] div_quo_q;
	logic [1:0]  div_axis_q;
	logic [15:0] trial;
	logic [15:0] diff;
	logic        ge;

	assign trial = {div_rem_q, div_quo_q[15]};
	assign diff  = trial - {1'b0, div_d_q};
	assign ge    = trial >= {1'b0, div_d_q};

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			div_d_q    <= raw_rd[14:0];
			div_rem_q  <= num_q[30:16];
			div_quo_q  <= num_q[15:0];
			div_axis_q <= cmd.axis;
		end else if (div_busy_q) begin
			div_rem_q <= ge ? diff[14:0] : trial[14:0];
			div_quo_q <= {div_quo_q[14:0], ge};
		end
	end

	// Field computation.
	logic signed [32:0] prod_w;
	logic signed [31:0] prod_q;
	logic [15:0]        scaled;
	logic [15:0]        signed_v;
	logic [15:0]        fld_w;
	logic [16:0]        mag_w;
	logic               fld_bad;

	assign prod_w   = raw_rd * $signed({1'b0, gain_rd});
	assign scaled   = prod_q[29:14];
	assign signed_v = neg_w ? (16'h0000 - scaled) : scaled;
	assign fld_w    = signed_v - {off_rd[15], off_rd[15:1]};
	assign mag_w    = fld_w[15] ? (17'h00000 - {fld_w[15], fld_w}) : {1'b0, fld_w};
	assign fld_bad  = mag_w >= {2'b00, lim_q};

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_q <= prod_w[31:0];
		end
	end

	// Gains, divider control and the pass flag.
	logic ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gains_q[0] <= GAIN_RST;
			gains_q[1] <= GAIN_RST;
			gains_q[2] <= GAIN_RST;
			div_busy_q <= 1'b0;
			div_done_q <= 1'b0;
			div_cnt_q  <= '0;
			ok_q       <= 1'b1;
		end else begin
			div_done_q <= 1'b0;
			if (cmd.load) begin
				ok_q <= 1'b1;
			end
			if (cmd.div_start) begin
				if (!d_good) begin
					gains_q[cmd.axis] <= dflt_q;
					ok_q              <= 1'b0;
					div_done_q        <= 1'b1;
				end else if (d_sat) begin
					gains_q[cmd.axis] <= GAIN_SAT;
					div_done_q        <= 1'b1;
				end else begin
					div_busy_q <= 1'b1;
					div_cnt_q  <= DIV_CNT_TOP;
				end
			end else if (div_busy_q) begin
				div_cnt_q <= div_cnt_q - 4'd1;
				if (div_cnt_q == '0) begin
					gains_q[div_axis_q] <= {div_quo_q[14:0], ge};
					div_busy_q          <= 1'b0;
					div_done_q          <= 1'b1;
				end
			end
			if (cmd.fld && fld_bad) begin
				ok_q <= 1'b0;
			end
		end
	end

	// Field results.
	logic [15:0] fld_q [3];

	always_ff @(posedge clk) begin
		if (cmd.load || cmd.clr_fld) begin
			fld_q[0] <= '0;
			fld_q[1] <= '0;
			fld_q[2] <= '0;
		end else if (cmd.fld) begin
			fld_q[cmd.axis] <= fld_w;
		end
	end

	assign sts.div_done = div_done_q;
	assign sts.ok       = ok_q;

	// Output register.
	mpcs_out_t out_q;

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_q.action           <= cmd.act;
			out_q.field_x          <= fld_q[0];
			out_q.field_y          <= fld_q[1];
			out_q.field_z          <= fld_q[2];
			out_q.gain_word_first  <= gains_q[0];
			out_q.gain_word_second <= gains_q[1];
			out_q.gain_word_third  <= gains_q[2];
		end
	end

	assign out_data = out_q;

endmodule

@@ rtl/mpcs_ctrl.sv @@
`include "assert_macros.svh"

module mpcs_ctrl
	import mpcs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] req_type,
	output logic       out_valid,
	input  logic       out_ready,
	output mpcs_cmd_t  cmd,
	input  mpcs_sts_t  sts
);

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_DISP   = 9'b000000010,
		S_CSTART = 9'b000000100,
		S_CWAIT  = 9'b000001000,
		S_CEND   = 9'b000010000,
		S_MUL    = 9'b000100000,
		S_FLD    = 9'b001000000,
		S_DEND   = 9'b010000000,
		S_PUSH   = 9'b100000000
	} state_t;

	state_t     state_q, state_d;
	logic [2:0] step_q, step_d, step_inc;
	logic [1:0] pause_q, pause_d;
	logic [1:0] req_q;
	logic [1:0] axis_q, axis_d;
	logic [3:0] act_q, act_d;
	logic       out_valid_q, out_valid_d;

	assign step_inc = (step_q == STEP_DATA) ? STEP_DATA : (step_q + 3'd1);

	always_comb begin
		state_d     = state_q;
		step_d      = step_q;
		pause_d     = pause_q;
		axis_d      = axis_q;
		act_d       = act_q;
		out_valid_d = out_valid_q;
		cmd         = '0;
		cmd.axis    = axis_q;
		cmd.act     = act_q;
		if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				axis_d  = AXIS_FIRST;
				state_d = S_PUSH;
				act_d   = ACT_NONE;
				case (req_q)
					REQ_FAULT: begin
						step_d = STEP_START;
						act_d  = ACT_BUS_REINIT;
					end
					REQ_NACK: begin
						step_d = STEP_START;
						act_d  = ACT_RESTART;
					end
					REQ_TICK: begin
						if (pause_q != '0) begin
							pause_d = pause_q - 2'd1;
						end else begin
							step_d = step_inc;
							case (step_inc)
								STEP_RESET: act_d = ACT_WR_RESET;
								STEP_SELFTEST: begin
									act_d   = ACT_WR_SELFTEST;
									pause_d = PAUSE_TICKS;
								end
								STEP_CONT: act_d = ACT_WR_CONT;
								default:   act_d = ACT_START_READ;
							endcase
						end
					end
					default: begin
						if (step_q == STEP_CAL) begin
							state_d = S_CSTART;
						end else if (step_q == STEP_DATA) begin
							state_d = S_MUL;
						end
					end
				endcase
			end
			S_CSTART: begin
				cmd.div_start = 1'b1;
				state_d       = S_CWAIT;
			end
			S_CWAIT: begin
				if (sts.div_done) begin
					if (axis_q == AXIS_LAST) begin
						state_d = S_CEND;
					end else begin
						axis_d  = axis_q + 2'd1;
						state_d = S_CSTART;
					end
				end
			end
			S_CEND: begin
				if (sts.ok) begin
					act_d = ACT_GAINS;
				end else begin
					act_d  = ACT_RESTART;
					step_d = STEP_START;
				end
				state_d = S_PUSH;
			end
			S_MUL: begin
				cmd.mul = 1'b1;
				state_d = S_FLD;
			end
			S_FLD: begin
				cmd.fld = 1'b1;
				if (axis_q == AXIS_LAST) begin
					state_d = S_DEND;
				end else begin
					axis_d  = axis_q + 2'd1;
					state_d = S_MUL;
				end
			end
			S_DEND: begin
				if (sts.ok) begin
					act_d = ACT_FIELD;
				end else begin
					act_d       = ACT_RESTART;
					step_d      = STEP_START;
					cmd.clr_fld = 1'b1;
				end
				state_d = S_PUSH;
			end
			S_PUSH: begin
				if (!out_valid_q || out_ready) begin
					cmd.push    = 1'b1;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= STEP_START;
			pause_q     <= '0;
			axis_q      <= AXIS_FIRST;
			act_q       <= ACT_NONE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			step_q      <= step_d;
			pause_q     <= pause_d;
			axis_q      <= axis_d;
			act_q       <= act_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req_type;
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	`MPCS_ASSERT(a_restart_step, cmd.push && (act_q == ACT_RESTART || act_q == ACT_BUS_REINIT) |-> step_q == STEP_START, "restart result issued with nonzero step")
	`MPCS_ASSERT(a_field_ok, cmd.push && act_q == ACT_FIELD |-> sts.ok, "field result issued after a failed range check")
	`MPCS_ASSERT(a_div_done_wait, sts.div_done |-> state_q == S_CWAIT, "divider finished outside the calibration wait")
	`MPCS_ASSERT_NEXT(a_push_stall, state_q == S_PUSH && out_valid_q && !out_ready, state_q == S_PUSH, "result left the push state while the output was full")

endmodule

@@ rtl/magnetometer_poll_calibrate_sequencer_top.sv @@
// Bring-up and polling sequencer for a three-axis magnetometer. Each input item is
// a request: a tick, a completed read carrying three raw sensor words, a NACK or a bus
// fault, and each request yields exactly one result item with an action code, the
// scaled field (non-zero only with a valid field report) and the three current gains.
// Ticks walk a saturating step counter through flush read, reset, flush read,
// self-test (followed by a two-tick pause), calibration read, continuous mode and then
// repeated data reads; a NACK, a bus fault or an out-of-range reading sends the
// sequence back to its start. The block handles one item at a time. A data read uses
// one shared 16x17 multiplier, which serves the three axes in turn. For a calibration
// read the restoring divider produces one quotient bit per cycle for each of the three
// gains in turn (a word that is out of range or whose gain saturates skips the
// division). A new item is taken in the cycle after its predecessor's result has
// entered the output register, so a result waiting on a stalled consumer does not hold
// up the next request. Configuration writes are taken at any time through the plain
// write port, but should only be issued while the block is idle.
module magnetometer_poll_calibrate_sequencer_top
	import mpcs_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  mpcs_in_t               in_data,
	output logic                   out_valid,
	input  logic                   out_ready,
	output mpcs_out_t              out_data,
	input  logic                   cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data
);

	// Command and status between the sequencing controller and the datapath.
	mpcs_cmd_t cmd;
	mpcs_sts_t sts;

	// The controller owns the step counter, the self-test pause and the handshakes.
	mpcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.req_type  (in_data.req_type),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// The datapath holds the configuration, the gains, the divider, the multiplier
	// and the output register.
	mpcs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule

@@ dv/tb_magnetometer_poll_calibrate_sequencer_top.sv @@
`timescale 1ns / 1ps

module tb_magnetometer_poll_calibrate_sequencer_top
	import mpcs_pkg::*;
();

	// The block scales by gain / 2^14, so the gain is fixed point with 14 fraction bits.
	localparam int GAIN_FRAC_BITS = 14;
	// After this many results the receiver holds off for a long stretch. The block then
	// fills up and stalls its input while the sender keeps offering items.
	localparam int HOLD_AT_RESULT = 300;
	localparam int HOLD_CYCLES    = 400;
	// A calibration read is the slowest item. The drain wait at the end allows for it
	// with some margin.
	localparam int DRAIN_CYCLES   = 100;
	localparam int NUM_PHASES     = 7;
	localparam int MAX_REPORTS    = 10;

	// The kinds of register setting that a phase can use.
	typedef enum int {
		SET_NOMINAL,
		SET_HIGH_EXTREMES,
		SET_LOW_EXTREMES,
		SET_RANDOM
	} setting_kind_t;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	mpcs_in_t  in_data;
	logic      out_valid;
	logic      out_ready;
	mpcs_out_t out_data;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// This class tracks the sequencer's state and registers on its own. For every
	// request item that the block accepts, it queues the report item the block should
	// produce. It then checks each report item that leaves the block against the
	// oldest one in the queue.
	class poll_report_scoreboard;
		mpcs_out_t   expected_reports[$];
		logic [2:0]  step;
		logic [1:0]  pause_left;
		int          gain[3];
		int          offset[3];
		int          field_limit;
		int          calib_floor;
		longint      gain_numerator;
		int          default_gain;
		int          axis_layout;
		int          mismatches;

		function new();
			step           = STEP_START;
			pause_left     = '0;
			for (int i = 0; i < 3; i++) begin
				gain[i]   = GAIN_RST;
				offset[i] = 0;
			end
			field_limit    = FIELD_LIMIT_RST;
			calib_floor    = CALIB_FLOOR_RST;
			gain_numerator = GAIN_NUMERATOR_RST;
			default_gain   = DEFAULT_GAIN_RST;
			axis_layout    = AXIS_LAYOUT_RST;
			mismatches     = 0;
		endfunction

		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				CFG_OFFSET_X:       offset[0]      = $signed(value[15:0]);
				CFG_OFFSET_Y:       offset[1]      = $signed(value[15:0]);
				CFG_OFFSET_Z:       offset[2]      = $signed(value[15:0]);
				CFG_FIELD_LIMIT:    field_limit    = value[14:0];
				CFG_CALIB_FLOOR:    calib_floor    = value[14:0];
				CFG_GAIN_NUMERATOR: gain_numerator = value[30:0];
				CFG_DEFAULT_GAIN:   default_gain   = value[15:0];
				CFG_AXIS_LAYOUT:    axis_layout    = value[8:0];
				default: ;
			endcase
		endfunction

		// Advances the state by one accepted request and queues the report it causes.
		function void predict_report(mpcs_in_t req);
			mpcs_out_t   rep;
			longint      raw[3];
			longint      q;
			longint      v;
			int          fld[3];
			int          mag;
			int          sel;
			logic [15:0] wrapped;
			bit          good;
			rep    = '0;
			raw[0] = $signed(req.raw_first);
			raw[1] = $signed(req.raw_second);
			raw[2] = $signed(req.raw_third);
			case (req.req_type)
				REQ_FAULT: begin
					step       = STEP_START;
					rep.action = ACT_BUS_REINIT;
				end
				REQ_NACK: begin
					step       = STEP_START;
					rep.action = ACT_RESTART;
				end
				REQ_TICK: begin
					if (pause_left != 0) begin
						pause_left = pause_left - 1'b1;
						rep.action = ACT_NONE;
					end else begin
						if (step != STEP_DATA)
							step = step + 1'b1;
						case (step)
							STEP_RESET: rep.action = ACT_WR_RESET;
							STEP_SELFTEST: begin
								rep.action = ACT_WR_SELFTEST;
								pause_left = PAUSE_TICKS;
							end
							STEP_CONT: rep.action = ACT_WR_CONT;
							default: rep.action = ACT_START_READ;
						endcase
					end
				end
				default: begin
					if (step == STEP_CAL) begin
						good = 1'b1;
						for (int i = 0; i < 3; i++) begin
							if (raw[i] > calib_floor && raw[i] < field_limit) begin
								q       = gain_numerator / raw[i];
								gain[i] = (q > GAIN_SAT) ? int'(GAIN_SAT) : int'(q);
							end else begin
								gain[i] = default_gain;
								good    = 1'b0;
							end
						end
						if (good) begin
							rep.action = ACT_GAINS;
						end else begin
							step       = STEP_START;
							rep.action = ACT_RESTART;
						end
					end else if (step == STEP_DATA) begin
						good = 1'b1;
						for (int i = 0; i < 3; i++) begin
							sel = (axis_layout >> (2 * i)) & 3;
							v   = 0;
							if (sel != AXIS_NONE)
								v = (raw[sel] * gain[sel]) >>> GAIN_FRAC_BITS;
							if ((axis_layout >> (6 + i)) & 1)
								v = -v;
							v       = v - (offset[i] >>> 1);
							wrapped = v[15:0];
							fld[i]  = $signed(wrapped);
							mag     = (fld[i] < 0) ? -fld[i] : fld[i];
							if (mag >= field_limit)
								good = 1'b0;
						end
						if (good) begin
							rep.action  = ACT_FIELD;
							rep.field_x = fld[0][15:0];
							rep.field_y = fld[1][15:0];
							rep.field_z = fld[2][15:0];
						end else begin
							step       = STEP_START;
							rep.action = ACT_RESTART;
						end
					end else begin
						rep.action = ACT_NONE;
					end
				end
			endcase
			rep.gain_word_first  = gain[0][15:0];
			rep.gain_word_second = gain[1][15:0];
			rep.gain_word_third  = gain[2][15:0];
			expected_reports.push_back(rep);
		endfunction

		function void check_report(mpcs_out_t got);
			mpcs_out_t exp_rep;
			if (expected_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: report item with none outstanding: act=%0d", $realtime,
						got.action);
				return;
			end
			exp_rep = expected_reports.pop_front();
			if (got.action !== exp_rep.action || got.field_x !== exp_rep.field_x ||
					got.field_y !== exp_rep.field_y || got.field_z !== exp_rep.field_z ||
					got.gain_word_first !== exp_rep.gain_word_first ||
					got.gain_word_second !== exp_rep.gain_word_second ||
					got.gain_word_third !== exp_rep.gain_word_third) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("%0t: mismatch, expected act=%0d fld=%0d/%0d/%0d gain=%0d/%0d/%0d",
						$realtime, exp_rep.action, exp_rep.field_x, exp_rep.field_y,
						exp_rep.field_z, exp_rep.gain_word_first, exp_rep.gain_word_second,
						exp_rep.gain_word_third);
					$display("%0t:           got act=%0d fld=%0d/%0d/%0d gain=%0d/%0d/%0d",
						$realtime, got.action, got.field_x, got.field_y, got.field_z,
						got.gain_word_first, got.gain_word_second, got.gain_word_third);
				end
			end
		endfunction

		function int pending();
			return expected_reports.size();
		endfunction
	endclass

	poll_report_scoreboard sb = new();
	int  n_sent    = 0;
	int  n_results = 0;
	bit  sender_steady = 1'b0;

	magnetometer_poll_calibrate_sequencer_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// The handshake signals from the block are sampled straight after the rising
	// edge. At that point they still hold the values they had before the edge, which
	// are the values that decide whether an item is accepted at that edge.

	// Offers one request item and returns at the edge where it is accepted. Valid is
	// only lowered when a gap is due, so back-to-back items keep it high without a
	// second assignment in the same time step.
	task automatic send_item(input mpcs_in_t item);
		int gap;
		if (n_sent % 40 == 0)
			sender_steady = ($urandom_range(0, 3) == 0);
		gap = sender_steady ? 0 : $urandom_range(0, 5);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do @(posedge clk); while (in_ready !== 1'b1);
		sb.predict_report(item);
		n_sent++;
	endtask

	// Each register write lands at the edge that follows it. The scoreboard copy is
	// updated at that same edge.
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value[CFG_DATA_W-1:0];
		@(posedge clk);
		sb.set_register(idx, value[CFG_DATA_W-1:0]);
	endtask

	task automatic apply_setting(input setting_kind_t kind);
		int lim;
		case (kind)
			SET_NOMINAL: begin
				write_register(CFG_OFFSET_X, int'($urandom_range(0, 400)) - 200);
				write_register(CFG_OFFSET_Y, int'($urandom_range(0, 400)) - 200);
				write_register(CFG_OFFSET_Z, int'($urandom_range(0, 400)) - 200);
				write_register(CFG_FIELD_LIMIT, FIELD_LIMIT_RST);
				write_register(CFG_CALIB_FLOOR, CALIB_FLOOR_RST);
				write_register(CFG_GAIN_NUMERATOR, GAIN_NUMERATOR_RST);
				write_register(CFG_DEFAULT_GAIN, DEFAULT_GAIN_RST);
				write_register(CFG_AXIS_LAYOUT, AXIS_LAYOUT_RST);
			end
			SET_HIGH_EXTREMES: begin
				// The widest window and the largest numerator make every gain
				// saturate. With all selectors off, the fields are set by the
				// offsets alone.
				write_register(CFG_OFFSET_X, -32768);
				write_register(CFG_OFFSET_Y, 32767);
				write_register(CFG_OFFSET_Z, 0);
				write_register(CFG_FIELD_LIMIT, 32767);
				write_register(CFG_CALIB_FLOOR, 0);
				write_register(CFG_GAIN_NUMERATOR, 32'h7FFF_FFFF);
				write_register(CFG_DEFAULT_GAIN, 65535);
				write_register(CFG_AXIS_LAYOUT, 511);
			end
			SET_LOW_EXTREMES: begin
				// No calibration word or field can pass here, so every calibration or data read restarts.
				write_register(CFG_OFFSET_X, 32767);
				write_register(CFG_OFFSET_Y, -1);
				write_register(CFG_OFFSET_Z, 1);
				write_register(CFG_FIELD_LIMIT, 0);
				write_register(CFG_CALIB_FLOOR, 32767);
				write_register(CFG_GAIN_NUMERATOR, 0);
				write_register(CFG_DEFAULT_GAIN, 0);
				write_register(CFG_AXIS_LAYOUT, 0);
			end
			default: begin
				lim = $urandom_range(200, 32767);
				write_register(CFG_OFFSET_X, int'($urandom_range(0, 2000)) - 1000);
				write_register(CFG_OFFSET_Y, int'($urandom_range(0, 2000)) - 1000);
				write_register(CFG_OFFSET_Z, int'($urandom_range(0, 65535)) - 32768);
				write_register(CFG_FIELD_LIMIT, lim);
				write_register(CFG_CALIB_FLOOR, $urandom_range(0, lim / 2));
				write_register(CFG_GAIN_NUMERATOR, $urandom_range(1 << 20, 1 << 26));
				write_register(CFG_DEFAULT_GAIN, $urandom_range(0, 65535));
				write_register(CFG_AXIS_LAYOUT, $urandom_range(0, 511));
			end
		endcase
		cfg_wr_en <= 1'b0;
	endtask

	function automatic mpcs_in_t compose_request(logic [1:0] req, int a, int b, int c);
		mpcs_in_t r;
		r.req_type   = req;
		r.raw_first  = a[15:0];
		r.raw_second = b[15:0];
		r.raw_third  = c[15:0];
		return r;
	endfunction

	// Data words are mostly small, so that scaled fields often fall inside the limit
	// and the polling loop keeps running. Some words are larger or fully random.
	function automatic int data_word();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll < 6)
			return int'($urandom_range(0, 255)) - 128;
		else if (roll < 8)
			return int'($urandom_range(0, 8191)) - 4096;
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	function automatic int calib_word();
		if (sb.field_limit - sb.calib_floor >= 2 && $urandom_range(0, 7) != 0)
			return $urandom_range(sb.calib_floor + 1, sb.field_limit - 1);
		return int'($urandom_range(0, 65535)) - 32768;
	endfunction

	// Picks the next request from the state that the scoreboard predicts. Most items
	// follow the bring-up sequence: ticks until the calibration step, a calibration
	// read, then ticks on to continuous mode and data reads. A few NACKs, bus faults,
	// bad words and stray reads are mixed in as noise.
	function automatic mpcs_in_t make_request();
		mpcs_in_t r;
		int       roll;
		r    = compose_request(REQ_TICK, $urandom, $urandom, $urandom);
		roll = $urandom_range(0, 99);
		if (roll < 4) begin
			r.req_type = REQ_NACK;
		end else if (roll < 7) begin
			r.req_type = REQ_FAULT;
		end else if (sb.step == STEP_CAL) begin
			if (roll < 80) begin
				r.req_type   = REQ_READ;
				r.raw_first  = 16'(calib_word());
				r.raw_second = 16'(calib_word());
				r.raw_third  = 16'(calib_word());
			end
		end else if (sb.step == STEP_DATA) begin
			if (roll < 80) begin
				r.req_type   = REQ_READ;
				r.raw_first  = 16'(data_word());
				r.raw_second = 16'(data_word());
				r.raw_third  = 16'(data_word());
			end
		end else if (roll < 12) begin
			r.req_type = REQ_READ;
		end
		return r;
	endfunction

	// Lowers valid and waits until every queued report item has been received. Each
	// request gives exactly one report, so the block is idle at that point.
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
	endtask

	// The directed part runs at the reset values of the registers. It walks the whole
	// bring-up sequence twice. The first time, a read comes at a step that ignores it,
	// and a calibration read has words on the exclusive bounds, which makes it fail. The
	// second time, the calibration words lie just inside the bounds, and one of them makes
	// its gain saturate. After that come a valid data read, a tick with the step
	// saturated, a data read with extreme words that fails, a NACK and a bus fault.
	task automatic run_directed();
		send_item(compose_request(REQ_TICK, 0, 0, 0));
		send_item(compose_request(REQ_TICK, 0, 0, 0));
		send_item(compose_request(REQ_READ, 32767, -32768, -1));
		repeat (5) send_item(compose_request(REQ_TICK, 0, 0, 0));
		send_item(compose_request(REQ_READ, 100, 1000, 500));
		repeat (7) send_item(compose_request(REQ_TICK, -1, -1, -1));
		send_item(compose_request(REQ_READ, 101, 999, 500));
		repeat (2) send_item(compose_request(REQ_TICK, 0, 0, 0));
		send_item(compose_request(REQ_READ, 10, -10, 0));
		send_item(compose_request(REQ_TICK, 0, 0, 0));
		send_item(compose_request(REQ_READ, -32768, 32767, 1));
		send_item(compose_request(REQ_NACK, 0, 0, 0));
		send_item(compose_request(REQ_FAULT, -1, -1, -1));
	endtask

	// The receiver draws a stall before each item. It takes no stalls during some
	// stretches and holds off once for a long time.
	initial begin
		int stall;
		bit steady;
		out_ready = 1'b0;
		steady    = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (n_results % 50 == 0)
				steady = ($urandom_range(0, 2) == 0);
			stall = steady ? 0 : $urandom_range(0, 5);
			if (n_results == HOLD_AT_RESULT)
				stall = HOLD_CYCLES;
			if (stall != 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			sb.check_report(out_data);
			n_results++;
		end
	end

	// The main sequence: reset, the directed part, then random phases that each use
	// their own register setting. Registers are only written while the block is idle.
	initial begin
		setting_kind_t kind;
		int            n_items;
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		in_data   = '0;
		cfg_wr_en = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (int p = 0; p < NUM_PHASES; p++) begin
			settle();
			case (p)
				0, 6:    kind = SET_NOMINAL;
				1:       kind = SET_HIGH_EXTREMES;
				3:       kind = SET_LOW_EXTREMES;
				default: kind = SET_RANDOM;
			endcase
			apply_setting(kind);
			n_items = (kind == SET_LOW_EXTREMES) ? 100 : 233;
			repeat (n_items) send_item(make_request());
		end
		settle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Watchdog for the whole run. It is set well beyond the slowest correct run.
	initial begin
		#3_000_000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule
